// File: sv/pmsp_pkg.sv
// Package for the power meter sample processor: field widths, limits, reset
// values of the config registers, register index codes and sample kind codes.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package pmsp_pkg;

  // Field widths
  localparam int SAMPLE_W   = 10;
  localparam int POWER_W    = 16;
  localparam int SCALE_W    = 16;
  localparam int GAIN_W     = 32;
  localparam int DELAY_W    = 6;
  localparam int COUNT_W    = 8;
  localparam int HELD_W     = SAMPLE_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Default depth of the voltage delay store
  localparam int DELAY_DEPTH_DEF = 50;

  // Fixed limits
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 10'd1023;
  localparam logic [COUNT_W-1:0]  QUIET_LIMIT = 8'd255;
  localparam logic [COUNT_W-1:0]  WINDOW_LEN  = 8'd255;
  localparam int                  GAIN_FRAC   = 24;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] ADC_OFFSET_RST = 10'd512;
  localparam logic [SCALE_W-1:0]  VOLT_SCALE_RST = 16'd145;
  localparam logic [GAIN_W-1:0]   POWER_GAIN_RST = 32'd417703;
  localparam logic [DELAY_W-1:0]  VOLT_DELAY_RST = 6'd0;
  localparam logic [SAMPLE_W-1:0] LOW_THR_RST    = 10'd700;

  // Configuration register index codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_OFFSET    = 3'd0,
    REG_VOLTAGE_SCALE = 3'd1,
    REG_POWER_GAIN    = 3'd2,
    REG_VOLTAGE_DELAY = 3'd3,
    REG_LOW_RANGE_THR = 3'd4
  } cfg_reg_e;

  // Sample kind codes
  localparam logic ACT_VOLTAGE = 1'b0;
  localparam logic ACT_CURRENT = 1'b1;

endpackage

// File: sv/pmsp_if.sv
// Request and result channel interfaces of the power meter sample processor.
// Depends on pmsp_pkg for the payload widths.
`timescale 1ns / 1ps

interface pmsp_in_if;
  import pmsp_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

interface pmsp_out_if;
  import pmsp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POWER_W-1:0] power;
  logic                      volt_absent;
  logic                      low_range;

  modport source (output valid, output power, output volt_absent, output low_range,
                  input ready);
  modport sink   (input valid, input power, input volt_absent, input low_range,
                  output ready);
endinterface

// File: sv/power_meter_sample_processor_core.sv
// Top level of the power meter sample processor: ranging, voltage window,
// delay store and the shared multiplier sequencer.
// Depends on pmsp_pkg and the channel interfaces in pmsp_if.sv.
`timescale 1ns / 1ps

// Takes one 10-bit sample request at a time (current or voltage) and returns
// one result per request: the held power value, the no-voltage flag and the
// current range. A current request passes through the states S_CUR and S_OUT.
// A voltage request passes through S_REDUCE, S_WRITE, S_READ (only with the
// delay in use), S_OPND, S_MUL1, S_MUL2, S_SAT and S_OUT; S_REDUCE repeats
// once per subtraction when the delay index has to be brought below a newly
// written, shorter delay length. S_OUT waits until the output register is
// free. The single multiplier is used once for the voltage times current
// product and once more for the gain. The input is not ready while a request
// is in work; a finished result waits in the output register while the next
// request is taken. The delay store is a memory with registered read and one
// valid flip-flop per entry, so it reads as zero after reset with no clearing
// pass.
module power_meter_sample_processor_core
  import pmsp_pkg::*;
#(
  parameter int DELAY_DEPTH = pmsp_pkg::DELAY_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pmsp_in_if.sink                          in_if,
  pmsp_out_if.source                       out_if,
  input  logic                             cfg_we_i,
  input  logic [pmsp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pmsp_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int AW   = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int DCAP = (DELAY_DEPTH > 63) ? 63 : DELAY_DEPTH;
  localparam logic [DELAY_W-1:0] DCAP_W = DELAY_W'(DCAP);
  localparam int MUL_A_W = 21;
  localparam int PROD_W  = MUL_A_W + GAIN_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CUR,
    S_REDUCE,
    S_WRITE,
    S_READ,
    S_OPND,
    S_MUL1,
    S_MUL2,
    S_SAT,
    S_OUT
  } state_e;

  // Configuration registers
  logic [SAMPLE_W-1:0] off_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [DELAY_W-1:0]  vdly_q;
  logic [SAMPLE_W-1:0] thr_q;

  // Sequencer and block state
  state_e                    state_q, state_d;
  logic [SAMPLE_W-1:0]       smp_q, smp_d;
  logic                      range_q, range_d;
  logic [HELD_W-1:0]         hc_q, hc_d;
  logic                      hcm_q, hcm_d;
  logic [SAMPLE_W-1:0]       peak_q, peak_d;
  logic [COUNT_W-1:0]        quiet_q, quiet_d;
  logic [COUNT_W-1:0]        wcnt_q, wcnt_d;
  logic [SAMPLE_W-1:0]       wmax_q, wmax_d;
  logic [SAMPLE_W-1:0]       wmin_q, wmin_d;
  logic                      nov_q, nov_d;
  logic [DELAY_W-1:0]        idx_q, idx_d;
  logic signed [POWER_W-1:0] power_q, power_d;
  logic                      rvalid_q, rvalid_d;
  logic [MUL_A_W-1:0]        mul_a_q, mul_a_d;
  logic [GAIN_W-1:0]         mul_b_q, mul_b_d;
  logic                      neg_q, neg_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic                      ov_q, ov_d;
  logic signed [POWER_W-1:0] opow_q, opow_d;
  logic                      onov_q, onov_d;
  logic                      orng_q, orng_d;

  // Delay store
  logic [SAMPLE_W-1:0]    mem [DELAY_DEPTH];
  logic [DELAY_DEPTH-1:0] vld_q;
  logic [SAMPLE_W-1:0]    rdata_q;
  logic [AW-1:0]          mem_addr;
  logic                   mem_we;

  // Datapath helpers
  logic [DELAY_W-1:0]   dlen;
  logic                 in_acc;
  logic [PROD_W-1:0]    mul_p;
  logic [SAMPLE_W-1:0]  delayed;
  logic signed [11:0]   sv;
  logic signed [12:0]   sc;
  logic [10:0]          sv_mag;
  logic [11:0]          sc_mag;
  logic signed [17:0]   twice_swing;
  logic [PROD_W-GAIN_FRAC-1:0] q_mag;
  logic [SAMPLE_W-1:0]  pk1;
  logic [COUNT_W-1:0]   qc1;
  logic                 r1;
  logic [COUNT_W-1:0]   wc1;
  logic [SAMPLE_W-1:0]  wmax1;
  logic [SAMPLE_W-1:0]  wmin1;
  logic                 nov1;

  // Effective delay length, capped by the store depth
  assign dlen     = (vdly_q > DCAP_W) ? DCAP_W : vdly_q;
  assign mem_addr = AW'(idx_q);
  assign mem_we   = (state_q == S_WRITE) && (dlen != '0);
  assign in_acc   = in_if.valid && in_if.ready;

  // Shared multiplier
  assign mul_p = {{(PROD_W-MUL_A_W){1'b0}}, mul_a_q} * {{(PROD_W-GAIN_W){1'b0}}, mul_b_q};

  assign in_if.ready        = (state_q == S_IDLE);
  assign out_if.valid       = ov_q;
  assign out_if.power       = opow_q;
  assign out_if.volt_absent = onov_q;
  assign out_if.low_range   = orng_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= ADC_OFFSET_RST;
      scale_q <= VOLT_SCALE_RST;
      gain_q  <= POWER_GAIN_RST;
      vdly_q  <= VOLT_DELAY_RST;
      thr_q   <= LOW_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ADC_OFFSET:    off_q   <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_VOLTAGE_SCALE: scale_q <= cfg_wdata_i[SCALE_W-1:0];
        REG_POWER_GAIN:    gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        REG_VOLTAGE_DELAY: vdly_q  <= cfg_wdata_i[DELAY_W-1:0];
        REG_LOW_RANGE_THR: thr_q   <= cfg_wdata_i[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Delay store: write one entry, registered read of one entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= smp_q;
    end
    if (state_q == S_READ) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // Mark written entries; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[mem_addr] <= 1'b1;
    end
  end

  // Current ranging update
  always_comb begin
    pk1 = (smp_q > peak_q) ? smp_q : peak_q;
    qc1 = ((pk1 < thr_q) && !range_q) ? quiet_q + 8'd1 : '0;
    r1  = range_q;
    if (qc1 == QUIET_LIMIT) begin
      r1  = 1'b1;
      pk1 = '0;
      qc1 = '0;
    end
    if (pk1 == SAMPLE_MAX) begin
      r1  = 1'b0;
      pk1 = '0;
      qc1 = '0;
    end
  end

  // Voltage window update
  always_comb begin
    twice_swing = ($signed({8'b0, wmax_q}) - $signed({8'b0, wmin_q})) <<< 1;
    wc1   = wcnt_q + 8'd1;
    wmax1 = wmax_q;
    wmin1 = wmin_q;
    nov1  = nov_q;
    if (wc1 == WINDOW_LEN) begin
      nov1  = (twice_swing < $signed({2'b0, scale_q}));
      wmax1 = '0;
      wmin1 = SAMPLE_MAX;
      wc1   = '0;
    end
    if (smp_q > wmax1) wmax1 = smp_q;
    if (smp_q < wmin1) wmin1 = smp_q;
  end

  // Signed operands and their magnitudes
  always_comb begin
    delayed = (dlen == '0) ? smp_q : (rvalid_q ? rdata_q : '0);
    sv = $signed({2'b0, delayed}) - $signed({2'b0, off_q});
    if (!hcm_q) begin
      sc = $signed({2'b0, hc_q}) - $signed({2'b0, off_q, 1'b0});
    end else begin
      sc = $signed({2'b0, hc_q}) - $signed({3'b0, off_q});
    end
    sv_mag = sv[11] ? 11'(-sv) : 11'(sv);
    sc_mag = sc[12] ? 12'(-sc) : 12'(sc);
    q_mag  = prod_q[PROD_W-1:GAIN_FRAC];
  end

  // Sequencer next state
  always_comb begin
    state_d  = state_q;
    smp_d    = smp_q;
    range_d  = range_q;
    hc_d     = hc_q;
    hcm_d    = hcm_q;
    peak_d   = peak_q;
    quiet_d  = quiet_q;
    wcnt_d   = wcnt_q;
    wmax_d   = wmax_q;
    wmin_d   = wmin_q;
    nov_d    = nov_q;
    idx_d    = idx_q;
    power_d  = power_q;
    rvalid_d = rvalid_q;
    mul_a_d  = mul_a_q;
    mul_b_d  = mul_b_q;
    neg_d    = neg_q;
    prod_d   = prod_q;
    ov_d     = ov_q;
    opow_d   = opow_q;
    onov_d   = onov_q;
    orng_d   = orng_q;

    // Drop the result once taken
    if (ov_q && out_if.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          smp_d   = in_if.sample;
          state_d = (in_if.action == ACT_CURRENT) ? S_CUR : S_REDUCE;
        end
      end
      S_CUR: begin
        hcm_d   = range_q;
        hc_d    = range_q ? {1'b0, smp_q} : {smp_q, 1'b0};
        peak_d  = pk1;
        quiet_d = qc1;
        range_d = r1;
        state_d = S_OUT;
      end
      S_REDUCE: begin
        // Bring a stale index below the delay length
        if ((dlen != '0) && (idx_q >= dlen)) begin
          idx_d = idx_q - dlen;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        wcnt_d = wc1;
        wmax_d = wmax1;
        wmin_d = wmin1;
        nov_d  = nov1;
        if (dlen != '0) begin
          idx_d   = ((idx_q + 6'd1) == dlen) ? '0 : idx_q + 6'd1;
          state_d = S_READ;
        end else begin
          state_d = S_OPND;
        end
      end
      S_READ: begin
        rvalid_d = vld_q[mem_addr];
        state_d  = S_OPND;
      end
      S_OPND: begin
        mul_a_d = MUL_A_W'(sv_mag);
        mul_b_d = GAIN_W'(sc_mag);
        neg_d   = sv[11] ^ sc[12];
        state_d = S_MUL1;
      end
      S_MUL1: begin
        // Voltage times current, then feed the gain
        mul_a_d = mul_p[MUL_A_W-1:0];
        mul_b_d = gain_q;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        prod_d  = mul_p;
        state_d = S_SAT;
      end
      S_SAT: begin
        if (!neg_q) begin
          power_d = (q_mag > 29'd32767) ? 16'sh7fff : $signed(q_mag[POWER_W-1:0]);
        end else begin
          power_d = (q_mag > 29'd32768) ? 16'sh8000 : $signed(-q_mag[POWER_W-1:0]);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!ov_q || out_if.ready) begin
          ov_d    = 1'b1;
          opow_d  = power_q;
          onov_d  = nov_q;
          orng_d  = range_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      smp_q    <= '0;
      range_q  <= 1'b0;
      hc_q     <= '0;
      hcm_q    <= 1'b0;
      peak_q   <= '0;
      quiet_q  <= '0;
      wcnt_q   <= '0;
      wmax_q   <= '0;
      wmin_q   <= SAMPLE_MAX;
      nov_q    <= 1'b0;
      idx_q    <= '0;
      power_q  <= '0;
      rvalid_q <= 1'b0;
      mul_a_q  <= '0;
      mul_b_q  <= '0;
      neg_q    <= 1'b0;
      prod_q   <= '0;
      ov_q     <= 1'b0;
      opow_q   <= '0;
      onov_q   <= 1'b0;
      orng_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      smp_q    <= smp_d;
      range_q  <= range_d;
      hc_q     <= hc_d;
      hcm_q    <= hcm_d;
      peak_q   <= peak_d;
      quiet_q  <= quiet_d;
      wcnt_q   <= wcnt_d;
      wmax_q   <= wmax_d;
      wmin_q   <= wmin_d;
      nov_q    <= nov_d;
      idx_q    <= idx_d;
      power_q  <= power_d;
      rvalid_q <= rvalid_d;
      mul_a_q  <= mul_a_d;
      mul_b_q  <= mul_b_d;
      neg_q    <= neg_d;
      prod_q   <= prod_d;
      ov_q     <= ov_d;
      opow_q   <= opow_d;
      onov_q   <= onov_d;
      orng_q   <= orng_d;
    end
  end

endmodule

// File: sv/pmsp_checker.sv
// Port-level checks for the power meter sample processor, bound to the top.
// Depends on pmsp_pkg for the payload widths.
`timescale 1ns / 1ps

module pmsp_checker
  import pmsp_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [POWER_W-1:0] power_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Hold the power of a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(power_i))
    else $error("power changed while stalled");

  // A request keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted back to back");

  // A new result only comes out of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without a request in work");

endmodule

bind power_meter_sample_processor_core pmsp_checker u_pmsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .power_i     (out_if.power)
);
